/* rtl/rbpt_pkg.sv */
// Shared types and constants for the beacon RSSI proximity tracker.
// Used by every module of the tracker; no dependencies.
`default_nettype none

package rbpt_pkg;

   // Presence states, also the encoding of the presence result field.
   typedef enum logic [1:0] {
      PRES_UNKNOWN  = 2'd0,
      PRES_AWAY     = 2'd1,
      PRES_APPROACH = 2'd2,
      PRES_FEEDER   = 2'd3
   } presence_type;

   typedef enum logic [1:0] {
      KIND_NONE  = 2'd0,
      KIND_UID   = 2'd1,
      KIND_TLM   = 2'd2,
      KIND_OTHER = 2'd3
   } kind_type;

   typedef enum logic {
      OP_REPORT = 1'b0,
      OP_TICK   = 1'b1
   } op_type;

   typedef enum logic [2:0] {
      CSR_TARGET_INSTANCE  = 3'd0,
      CSR_SMOOTHING_WEIGHT = 3'd1,
      CSR_AWAY_LEVEL       = 3'd2,
      CSR_FEEDER_LEVEL     = 3'd3,
      CSR_MARGIN_LEVEL     = 3'd4,
      CSR_WEAK_LEVEL       = 3'd5,
      CSR_LOST_TIMEOUT     = 3'd6,
      CSR_EXIT_DEBOUNCE    = 3'd7
   } csr_index_type;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 48;
   localparam int ADDR_W      = 48;
   localparam int LEVEL_W     = 10;   // a whole-dBm level plus or minus the margin

   // Address compare mask: five leading bytes plus the upper nibble of the last one.
   localparam int          PREFIX_BYTES = 5;
   localparam logic [7:0]  SUFFIX_MASK  = 8'hF0;
   localparam logic [ADDR_W-1:0] MAC_MASK = {{(8*PREFIX_BYTES){1'b1}}, SUFFIX_MASK};

   // Full weight of a new sample in Q0.8.
   localparam logic [8:0] WEIGHT_ONE = 9'd256;

   // Register reset values.
   localparam logic [47:0]        RST_TARGET_INSTANCE  = 48'd0;
   localparam logic [8:0]         RST_SMOOTHING_WEIGHT = 9'd77;
   localparam logic signed [7:0]  RST_AWAY_LEVEL       = -8'sd80;
   localparam logic signed [7:0]  RST_FEEDER_LEVEL     = -8'sd60;
   localparam logic [6:0]         RST_MARGIN_LEVEL     = 7'd5;
   localparam logic signed [7:0]  RST_WEAK_LEVEL       = -8'sd100;
   localparam logic [31:0]        RST_LOST_TIMEOUT     = 32'd10000;
   localparam logic [31:0]        RST_EXIT_DEBOUNCE    = 32'd2000;

   typedef struct packed {
      logic [47:0]        target_instance;
      logic [8:0]         smoothing_weight;
      logic signed [7:0]  away_level;
      logic signed [7:0]  feeder_level;
      logic [6:0]         margin_level;
      logic signed [7:0]  weak_level;
      logic [31:0]        lost_timeout;
      logic [31:0]        exit_debounce;
   } cfg_type;

   // An item after classification in the front end.
   typedef struct packed {
      op_type             operation;
      kind_type           kind;
      logic               instance_match;
      logic [ADDR_W-1:0]  mac;
      logic signed [7:0]  strength;
      logic [15:0]        battery;
   } item_type;

   typedef struct packed {
      presence_type       presence;
      logic               presence_changed;
      logic signed [15:0] average_strength;
      logic [15:0]        battery_reading;
      logic               address_learned;
      logic [31:0]        presence_time;
      logic [31:0]        strength_time;
      logic [31:0]        battery_time;
   } result_type;

endpackage

`default_nettype wire

/* rtl/rbpt_channel_if.sv */
// Valid/ready channel interfaces for tracker requests and responses.
// Does not depend on rbpt_pkg; its field widths are kept in step with it.
`default_nettype none

interface rbpt_req_if;
   logic              valid;
   logic              ready;
   logic              operation;
   logic [1:0]        frame_kind;
   logic [47:0]       frame_instance;
   logic [47:0]       sender_mac;
   logic signed [7:0] signal_strength;
   logic [15:0]       frame_battery;

   modport source (output valid, operation, frame_kind, frame_instance, sender_mac,
                   signal_strength, frame_battery, input ready);
   modport sink   (input valid, operation, frame_kind, frame_instance, sender_mac,
                   signal_strength, frame_battery, output ready);
endinterface

interface rbpt_rsp_if;
   logic               valid;
   logic               ready;
   logic [1:0]         presence;
   logic               presence_changed;
   logic signed [15:0] average_strength;
   logic [15:0]        battery_reading;
   logic               address_learned;
   logic [31:0]        presence_time;
   logic [31:0]        strength_time;
   logic [31:0]        battery_time;

   modport source (output valid, presence, presence_changed, average_strength,
                   battery_reading, address_learned, presence_time, strength_time,
                   battery_time, input ready);
   modport sink   (input valid, presence, presence_changed, average_strength,
                   battery_reading, address_learned, presence_time, strength_time,
                   battery_time, output ready);
endinterface

`default_nettype wire

/* rtl/beacon_rssi_proximity_tracker_core.sv */
// Beacon RSSI proximity tracker: one response item for every request item.
// A request passes through the front register, the queue and the back-end response register.
// Throughput: one item per cycle while the response channel is ready, set by the state
// update in the back end, which holds the average loop.
// Reset (synchronous, active high) restores register defaults, clears all tracker
// state, empties the queue and sets the average to the weak level.
`default_nettype none

module beacon_rssi_proximity_tracker_core #(
   parameter int TIME_WIDTH    = 32,
   parameter int FRACTION_BITS = 8
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   rbpt_req_if.sink                                  req_chan,
   rbpt_rsp_if.source                                rsp_chan,
   input  wire logic                                 csr_write_enable,
   input  wire logic [rbpt_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  wire logic [rbpt_pkg::CSR_DATA_W-1:0]      csr_write_data
);

   rbpt_pkg::cfg_type      cfg_ff, cfg_in;
   logic                   front_valid, front_ready;
   rbpt_pkg::item_type     front_item;
   logic                   queue_valid, queue_ready;
   rbpt_pkg::item_type     queue_item;
   rbpt_pkg::result_type   result;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         unique case (rbpt_pkg::csr_index_type'(csr_index))
            rbpt_pkg::CSR_TARGET_INSTANCE:  cfg_in.target_instance  = csr_write_data[47:0];
            rbpt_pkg::CSR_SMOOTHING_WEIGHT: cfg_in.smoothing_weight = csr_write_data[8:0];
            rbpt_pkg::CSR_AWAY_LEVEL:       cfg_in.away_level       = csr_write_data[7:0];
            rbpt_pkg::CSR_FEEDER_LEVEL:     cfg_in.feeder_level     = csr_write_data[7:0];
            rbpt_pkg::CSR_MARGIN_LEVEL:     cfg_in.margin_level     = csr_write_data[6:0];
            rbpt_pkg::CSR_WEAK_LEVEL:       cfg_in.weak_level       = csr_write_data[7:0];
            rbpt_pkg::CSR_LOST_TIMEOUT:     cfg_in.lost_timeout     = csr_write_data[31:0];
            rbpt_pkg::CSR_EXIT_DEBOUNCE:    cfg_in.exit_debounce    = csr_write_data[31:0];
            default:                        cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.target_instance  <= rbpt_pkg::RST_TARGET_INSTANCE;
         cfg_ff.smoothing_weight <= rbpt_pkg::RST_SMOOTHING_WEIGHT;
         cfg_ff.away_level       <= rbpt_pkg::RST_AWAY_LEVEL;
         cfg_ff.feeder_level     <= rbpt_pkg::RST_FEEDER_LEVEL;
         cfg_ff.margin_level     <= rbpt_pkg::RST_MARGIN_LEVEL;
         cfg_ff.weak_level       <= rbpt_pkg::RST_WEAK_LEVEL;
         cfg_ff.lost_timeout     <= rbpt_pkg::RST_LOST_TIMEOUT;
         cfg_ff.exit_debounce    <= rbpt_pkg::RST_EXIT_DEBOUNCE;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   rbpt_front u_front (
      .clock           (clock),
      .reset           (reset),
      .in_valid        (req_chan.valid),
      .in_ready        (req_chan.ready),
      .operation       (req_chan.operation),
      .frame_kind      (req_chan.frame_kind),
      .frame_instance  (req_chan.frame_instance),
      .sender_mac      (req_chan.sender_mac),
      .signal_strength (req_chan.signal_strength),
      .frame_battery   (req_chan.frame_battery),
      .target_instance (cfg_ff.target_instance),
      .out_valid       (front_valid),
      .out_ready       (front_ready),
      .out_item        (front_item)
   );

   rbpt_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (front_valid),
      .push_ready (front_ready),
      .push_item  (front_item),
      .pop_valid  (queue_valid),
      .pop_ready  (queue_ready),
      .pop_item   (queue_item)
   );

   rbpt_back #(
      .TIME_WIDTH    (TIME_WIDTH),
      .FRACTION_BITS (FRACTION_BITS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .in_valid   (queue_valid),
      .in_ready   (queue_ready),
      .in_item    (queue_item),
      .out_valid  (rsp_chan.valid),
      .out_ready  (rsp_chan.ready),
      .out_result (result)
   );

   assign rsp_chan.presence         = result.presence;
   assign rsp_chan.presence_changed = result.presence_changed;
   assign rsp_chan.average_strength = result.average_strength;
   assign rsp_chan.battery_reading  = result.battery_reading;
   assign rsp_chan.address_learned  = result.address_learned;
   assign rsp_chan.presence_time    = result.presence_time;
   assign rsp_chan.strength_time    = result.strength_time;
   assign rsp_chan.battery_time     = result.battery_time;

endmodule

`default_nettype wire

/* rtl/rbpt_queue.sv */
// Two-entry item queue between the tracker front end and back end.
// Depends on rbpt_pkg for the classified item type.
`default_nettype none

module rbpt_queue (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               push_valid,
   output logic                    push_ready,
   input  rbpt_pkg::item_type      push_item,
   output logic                    pop_valid,
   input  wire logic               pop_ready,
   output rbpt_pkg::item_type      pop_item
);

   localparam int DEPTH = 2;
   localparam int PTR_W = $clog2(DEPTH);

   rbpt_pkg::item_type     slot_ff [DEPTH];
   logic [PTR_W-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [PTR_W:0]         count_ff, count_in;
   logic                   do_push, do_pop;

   assign push_ready = (count_ff != (PTR_W+1)'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_item   = slot_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + (PTR_W+1)'(do_push) - (PTR_W+1)'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

`default_nettype wire

/* rtl/rbpt_front.sv */
// Front end of the tracker: accepts request items, matches the UID instance
// against the target and registers the classified item. Depends on rbpt_pkg.
`default_nettype none

module rbpt_front (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               in_valid,
   output logic                    in_ready,
   input  wire logic               operation,
   input  wire logic [1:0]         frame_kind,
   input  wire logic [47:0]        frame_instance,
   input  wire logic [47:0]        sender_mac,
   input  wire logic signed [7:0]  signal_strength,
   input  wire logic [15:0]        frame_battery,
   input  wire logic [47:0]        target_instance,
   output logic                    out_valid,
   input  wire logic               out_ready,
   output rbpt_pkg::item_type      out_item
);

   logic                  valid_ff, valid_in;
   rbpt_pkg::item_type    item_ff, item_in;
   logic                  take;

   assign in_ready  = !valid_ff || out_ready;
   assign take      = in_valid && in_ready;
   assign out_valid = valid_ff;
   assign out_item  = item_ff;

   always_comb begin
      valid_in               = take || (valid_ff && !out_ready);
      item_in.operation      = rbpt_pkg::op_type'(operation);
      item_in.kind           = rbpt_pkg::kind_type'(frame_kind);
      item_in.instance_match = (frame_instance == target_instance);
      item_in.mac            = sender_mac;
      item_in.strength       = signal_strength;
      item_in.battery        = frame_battery;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         item_ff <= item_in;
      end
   end

endmodule

`default_nettype wire

/* rtl/rbpt_back.sv */
// Back end of the tracker: address learning, battery latch, moving average,
// presence state machine, lost-signal timeout and the response register. Depends on rbpt_pkg.
`default_nettype none

module rbpt_back #(
   parameter int TIME_WIDTH    = 32,
   parameter int FRACTION_BITS = 8
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  rbpt_pkg::cfg_type       cfg,
   input  wire logic               in_valid,
   output logic                    in_ready,
   input  rbpt_pkg::item_type      in_item,
   output logic                    out_valid,
   input  wire logic               out_ready,
   output rbpt_pkg::result_type    out_result
);

   localparam int AW = 8 + FRACTION_BITS;                // stored average width
   localparam int LW = rbpt_pkg::LEVEL_W + FRACTION_BITS; // threshold width
   localparam int PW = AW + 11;                          // blend sum width
   localparam int CW = (TIME_WIDTH > 32) ? TIME_WIDTH : 32;

   localparam logic signed [AW-1:0] AVG_RESET =
      {rbpt_pkg::RST_WEAK_LEVEL, {FRACTION_BITS{1'b0}}};

   // Architectural state.
   logic [TIME_WIDTH-1:0]        tick_ff, tick_in;
   logic [rbpt_pkg::ADDR_W-1:0]  learned_ff, learned_in;
   logic                         learned_valid_ff, learned_valid_in;
   logic signed [AW-1:0]         avg_ff, avg_in;
   rbpt_pkg::presence_type       presence_ff, presence_in;
   logic                         pending_ff, pending_in;
   logic [TIME_WIDTH-1:0]        exit_start_ff, exit_start_in;
   logic [15:0]                  battery_ff, battery_in;
   logic [TIME_WIDTH-1:0]        change_stamp_ff, change_stamp_in;
   logic [TIME_WIDTH-1:0]        strength_stamp_ff, strength_stamp_in;
   logic [TIME_WIDTH-1:0]        battery_stamp_ff, battery_stamp_in;

   logic                         out_valid_ff, out_valid_in;
   rbpt_pkg::result_type         result_ff, result_in;

   logic                         fire;
   logic                         is_report, learn, target;
   logic [8:0]                   weight;
   logic signed [AW-1:0]         sample, weak_fix, blended, avg_upd;
   logic signed [AW:0]           delta;
   logic signed [PW-1:0]         product, blend_sum;
   logic signed [rbpt_pkg::LEVEL_W-1:0] away_w, feeder_w, margin_w;
   logic signed [LW-1:0]         lo_away, hi_away, feed, lo_feed, avg_cmp;
   logic [TIME_WIDTH-1:0]        lost_diff, exit_diff;
   logic [CW-1:0]                lost_elapsed, exit_elapsed;
   logic                         timed_out;

   assign fire      = in_valid && (!out_valid_ff || out_ready);
   assign in_ready  = !out_valid_ff || out_ready;
   assign out_valid = out_valid_ff;
   assign out_result = result_ff;

   // Classification against the learned address. The report that teaches the
   // address already counts as a target report.
   always_comb begin
      is_report = (in_item.operation == rbpt_pkg::OP_REPORT)
                  && (in_item.kind != rbpt_pkg::KIND_NONE);
      learn     = is_report && (in_item.kind == rbpt_pkg::KIND_UID)
                  && in_item.instance_match && !learned_valid_ff;
      if (learned_valid_ff) begin
         target = is_report
                  && (((in_item.mac ^ learned_ff) & rbpt_pkg::MAC_MASK) == '0);
      end else begin
         target = learn;
      end
   end

   // Moving average avg + w*(sample-avg)/256, rounded to nearest; sample if avg is weak.
   always_comb begin
      weight    = (cfg.smoothing_weight > rbpt_pkg::WEIGHT_ONE)
                  ? rbpt_pkg::WEIGHT_ONE : cfg.smoothing_weight;
      sample    = {in_item.strength, {FRACTION_BITS{1'b0}}};
      weak_fix  = {cfg.weak_level, {FRACTION_BITS{1'b0}}};
      delta     = (AW+1)'(sample) - (AW+1)'(avg_ff);
      product   = $signed({{(PW-9){1'b0}}, weight}) * PW'(delta);
      blend_sum = (PW'(avg_ff) <<< 8) + product + PW'(128);
      blended   = blend_sum[AW+7:8];
      avg_upd   = (avg_ff == weak_fix) ? sample : blended;
   end

   // Thresholds in the average's fixed-point format.
   always_comb begin
      away_w   = rbpt_pkg::LEVEL_W'(cfg.away_level);
      feeder_w = rbpt_pkg::LEVEL_W'(cfg.feeder_level);
      margin_w = $signed({3'b000, cfg.margin_level});
      lo_away  = {away_w - margin_w, {FRACTION_BITS{1'b0}}};
      hi_away  = {away_w + margin_w, {FRACTION_BITS{1'b0}}};
      feed     = {feeder_w, {FRACTION_BITS{1'b0}}};
      lo_feed  = {feeder_w - margin_w, {FRACTION_BITS{1'b0}}};
      avg_cmp  = LW'(avg_upd);
   end

   // Next state of the tracker for the item at the head of the queue.
   always_comb begin
      tick_in           = (in_item.operation == rbpt_pkg::OP_TICK) ? tick_ff + 1'b1 : tick_ff;
      learned_in        = learn ? in_item.mac : learned_ff;
      learned_valid_in  = learned_valid_ff || learn;
      battery_in        = battery_ff;
      battery_stamp_in  = battery_stamp_ff;
      avg_in            = avg_ff;
      strength_stamp_in = strength_stamp_ff;
      presence_in       = presence_ff;
      pending_in        = pending_ff;
      exit_start_in     = exit_start_ff;
      change_stamp_in   = change_stamp_ff;

      // Elapsed times wrap with the tick counter before they are compared.
      exit_diff    = tick_in - exit_start_ff;
      lost_diff    = tick_in - strength_stamp_ff;
      exit_elapsed = CW'(exit_diff);
      lost_elapsed = CW'(lost_diff);

      if (target && (in_item.kind == rbpt_pkg::KIND_TLM)) begin
         battery_in       = in_item.battery;
         battery_stamp_in = tick_in;
      end

      if (target) begin
         avg_in            = avg_upd;
         strength_stamp_in = tick_in;
         unique case (presence_ff) inside
            rbpt_pkg::PRES_UNKNOWN, rbpt_pkg::PRES_AWAY: begin
               if (avg_cmp >= hi_away) begin
                  presence_in = rbpt_pkg::PRES_APPROACH;
               end
            end
            rbpt_pkg::PRES_APPROACH: begin
               if (avg_cmp >= feed) begin
                  presence_in = rbpt_pkg::PRES_FEEDER;
               end else if (avg_cmp < lo_away) begin
                  presence_in = rbpt_pkg::PRES_AWAY;
               end
            end
            default: begin
               // At feeder: a low reading starts the debounce; a later low
               // reading after the debounce interval moves back to approaching.
               if (avg_cmp < lo_feed) begin
                  if (!pending_ff) begin
                     pending_in    = 1'b1;
                     exit_start_in = tick_in;
                  end else if (exit_elapsed >= CW'(cfg.exit_debounce)) begin
                     presence_in = rbpt_pkg::PRES_APPROACH;
                  end
               end else begin
                  pending_in = 1'b0;
               end
            end
         endcase
      end

      // A target report stamps the signal time now, so only an item without
      // one can run out the lost-signal timeout.
      timed_out = !target
                  && ((presence_ff == rbpt_pkg::PRES_APPROACH)
                      || (presence_ff == rbpt_pkg::PRES_FEEDER))
                  && (lost_elapsed > CW'(cfg.lost_timeout));
      if (timed_out) begin
         presence_in = rbpt_pkg::PRES_AWAY;
         avg_in      = weak_fix;
      end

      if (presence_in != presence_ff) begin
         pending_in      = 1'b0;
         change_stamp_in = tick_in;
      end

      result_in.presence         = presence_in;
      result_in.presence_changed = (presence_in != presence_ff);
      result_in.average_strength = 16'(avg_in);
      result_in.battery_reading  = battery_in;
      result_in.address_learned  = learned_valid_in;
      result_in.presence_time    = 32'(change_stamp_in);
      result_in.strength_time    = 32'(strength_stamp_in);
      result_in.battery_time     = 32'(battery_stamp_in);

      out_valid_in = fire || (out_valid_ff && !out_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tick_ff           <= '0;
         learned_ff        <= '0;
         learned_valid_ff  <= 1'b0;
         avg_ff            <= AVG_RESET;
         presence_ff       <= rbpt_pkg::PRES_UNKNOWN;
         pending_ff        <= 1'b0;
         exit_start_ff     <= '0;
         battery_ff        <= '0;
         change_stamp_ff   <= '0;
         strength_stamp_ff <= '0;
         battery_stamp_ff  <= '0;
         out_valid_ff      <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
         if (fire) begin
            tick_ff           <= tick_in;
            learned_ff        <= learned_in;
            learned_valid_ff  <= learned_valid_in;
            avg_ff            <= avg_in;
            presence_ff       <= presence_in;
            pending_ff        <= pending_in;
            exit_start_ff     <= exit_start_in;
            battery_ff        <= battery_in;
            change_stamp_ff   <= change_stamp_in;
            strength_stamp_ff <= strength_stamp_in;
            battery_stamp_ff  <= battery_stamp_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         result_ff <= result_in;
      end
   end

endmodule

`default_nettype wire
